// File: rtl/dhb_pkg.sv
// Shared types and constants for the delta heartbeat encoder.
// Holds the transaction payload structs, frame type codes and frame layout.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dhb_pkg;

    // Heartbeat sample carried by one input transaction
    typedef struct packed {
        logic [15:0]       device_short_id;
        logic [7:0]        status_code;
        logic [7:0]        battery_percent;
        logic signed [7:0] signal_strength;
        logic [15:0]       current_task;
    } t_hb_sample;

    // One frame byte carried by one output transaction
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } t_frame_beat;

    localparam int FrameBytesMax = 8;
    localparam int ByteIdxW      = $clog2(FrameBytesMax);

    typedef logic [ByteIdxW-1:0] t_byte_idx;

    // Whole frame handed from the framer to the serializer
    typedef struct packed {
        logic [FrameBytesMax-1:0][7:0] bytes;
        t_byte_idx                     last_idx;
    } t_frame;

    // Frame type codes, header bits 7:6
    localparam logic [1:0] FT_NO_CHANGE = 2'd0;
    localparam logic [1:0] FT_BATTERY   = 2'd1;
    localparam logic [1:0] FT_STATUS    = 2'd2;
    localparam logic [1:0] FT_FULL      = 2'd3;

    // Index of the last byte for each frame type
    localparam t_byte_idx LAST_NO_CHANGE = t_byte_idx'(2);
    localparam t_byte_idx LAST_BATTERY   = t_byte_idx'(3);
    localparam t_byte_idx LAST_STATUS    = t_byte_idx'(4);
    localparam t_byte_idx LAST_FULL      = t_byte_idx'(7);

    localparam logic [7:0] INTERVAL_RESET = 8'd10;

endpackage

`default_nettype wire

// File: rtl/dhb_framer.sv
// Frame builder: keeps the previous sample, sequence number and full-frame
// countdown, and turns one heartbeat sample into a complete frame.
// Depends on dhb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dhb_framer (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [7:0]         i_cfg_wdata,
    input  wire logic               i_load,
    input  wire dhb_pkg::t_hb_sample i_sample,
    output dhb_pkg::t_frame         o_frame
);
    import dhb_pkg::*;

    logic [7:0]  r_interval;
    logic [7:0]  r_countdown, n_countdown;
    logic [5:0]  r_seq;
    logic [7:0]  r_prev_status;
    logic [7:0]  r_prev_battery;
    logic [7:0]  r_prev_signal;
    logic [15:0] r_prev_task;

    logic [7:0]  cnt_dec;
    logic        is_full;
    logic        bat_chg, stat_chg, sig_chg, task_chg;
    logic [1:0]  frame_type;

    // Count down and compare against the stored sample
    always_comb begin
        cnt_dec  = r_countdown - 8'd1;
        is_full  = (cnt_dec == 8'd0);
        bat_chg  = (i_sample.battery_percent != r_prev_battery);
        stat_chg = (i_sample.status_code != r_prev_status);
        sig_chg  = ($unsigned(i_sample.signal_strength) != r_prev_signal);
        task_chg = (i_sample.current_task != r_prev_task);
        n_countdown = is_full ? r_interval : cnt_dec;
    end

    // Pick the frame type; forced full frame wins
    always_comb begin
        priority if (is_full) begin
            frame_type = FT_FULL;
        end else if (!bat_chg && !stat_chg && !sig_chg && !task_chg) begin
            frame_type = FT_NO_CHANGE;
        end else if (!stat_chg && !sig_chg && !task_chg) begin
            frame_type = FT_BATTERY;
        end else begin
            frame_type = FT_STATUS;
        end
    end

    // Lay out the frame bytes, least significant byte first
    always_comb begin
        o_frame          = '0;
        o_frame.bytes[0] = {frame_type, r_seq};
        o_frame.bytes[1] = i_sample.device_short_id[7:0];
        o_frame.bytes[2] = i_sample.device_short_id[15:8];
        unique case (frame_type)
            FT_NO_CHANGE: begin
                o_frame.last_idx = LAST_NO_CHANGE;
            end
            FT_BATTERY: begin
                o_frame.bytes[3] = i_sample.battery_percent;
                o_frame.last_idx = LAST_BATTERY;
            end
            FT_STATUS: begin
                o_frame.bytes[3] = i_sample.status_code;
                o_frame.bytes[4] = i_sample.battery_percent;
                o_frame.last_idx = LAST_STATUS;
            end
            default: begin
                o_frame.bytes[3] = i_sample.status_code;
                o_frame.bytes[4] = i_sample.battery_percent;
                o_frame.bytes[5] = $unsigned(i_sample.signal_strength);
                o_frame.bytes[6] = i_sample.current_task[7:0];
                o_frame.bytes[7] = i_sample.current_task[15:8];
                o_frame.last_idx = LAST_FULL;
            end
        endcase
    end

    // Hold the interval register; it only matters at the next reload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= INTERVAL_RESET;
        end else if (i_cfg_we) begin
            r_interval <= i_cfg_wdata;
        end
    end

    // Advance the encoder state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_countdown    <= INTERVAL_RESET;
            r_seq          <= '0;
            r_prev_status  <= '0;
            r_prev_battery <= '0;
            r_prev_signal  <= '0;
            r_prev_task    <= '0;
        end else if (i_load) begin
            r_countdown    <= n_countdown;
            r_seq          <= r_seq + 6'd1;
            r_prev_status  <= i_sample.status_code;
            r_prev_battery <= i_sample.battery_percent;
            r_prev_signal  <= $unsigned(i_sample.signal_strength);
            r_prev_task    <= i_sample.current_task;
        end
    end

endmodule

`default_nettype wire

// File: rtl/dhb_serializer.sv
// Frame register and byte serializer: holds one built frame and presents
// it one byte per output transaction. Depends on dhb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dhb_serializer (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire dhb_pkg::t_frame i_frame,
    output logic                 o_free,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output dhb_pkg::t_frame_beat o_data
);
    import dhb_pkg::*;

    t_frame    r_frame;
    t_byte_idx r_idx;
    logic      r_busy;
    logic      is_last;
    logic      beat_taken;

    always_comb begin
        is_last           = (r_idx == r_frame.last_idx);
        beat_taken        = r_busy && !i_stall;
        o_valid           = r_busy;
        o_data.frame_byte = r_frame.bytes[r_idx];
        o_data.frame_end  = is_last;
        // Room for a new frame when empty or the last byte leaves now
        o_free            = !r_busy || (beat_taken && is_last);
    end

    // Load a new frame, or step to the next byte when one is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (beat_taken) begin
            if (is_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + t_byte_idx'(1);
            end
        end
    end

    // Capture the frame payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_frame <= i_frame;
        end
    end

endmodule

`default_nettype wire

// File: rtl/delta_heartbeat_encoder.sv
// Top level of the delta heartbeat encoder.
// Instantiates dhb_framer and dhb_serializer; depends on dhb_pkg.
//
// Each heartbeat sample accepted on the input channel becomes one frame of
// 3, 4, 5 or 8 bytes, sent one byte per output transaction with frame_end
// set on the last byte. A frame is built in the cycle its sample is accepted
// and loaded into the frame register; bytes then leave at one per cycle
// while i_stall is low, and the input stays stalled until the last byte of
// the frame is taken. The next sample is accepted in the same cycle the
// last byte of the previous frame is taken, so frames follow each other without
// gaps. The full-frame interval register is written through i_cfg_we /
// i_cfg_wdata and takes effect at the next countdown reload.
`timescale 1ns / 1ps
`default_nettype none

module delta_heartbeat_encoder (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [7:0]           i_cfg_wdata,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire dhb_pkg::t_hb_sample  i_data,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output dhb_pkg::t_frame_beat      o_data
);
    import dhb_pkg::*;

    t_frame frame;
    logic   ser_free;
    logic   load;

    // Accept a transaction whenever the frame register can take a frame
    assign o_stall = !ser_free;
    assign load    = i_valid && ser_free;

    dhb_framer u_framer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_load      (load),
        .i_sample    (i_data),
        .o_frame     (frame)
    );

    dhb_serializer u_serializer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_frame (frame),
        .o_free  (ser_free),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // An accepted sample always produces output in the next cycle
    a_load_gives_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> o_valid)
        else $error("accepted sample produced no output byte");

    // A frame never breaks off before its last byte
    a_frame_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_data.frame_end |=> o_valid)
        else $error("frame ended without frame_end");

    // Input is stalled only while a frame is pending
    a_stall_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no frame pending");

    // Hold a stalled output byte unchanged until it is taken
    a_stalled_byte_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled output byte changed");

endmodule

`default_nettype wire

// File: bench/delta_heartbeat_encoder_tb.sv
// Self-checking testbench for delta_heartbeat_encoder.
// Drives heartbeat samples and interval writes, predicts every frame byte and checks
// the output beats in order. Depends on dhb_pkg and the encoder RTL.
`timescale 1ns / 1ps

module delta_heartbeat_encoder_tb;

    import dhb_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 16;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [7:0]  i_cfg_wdata = 8'h00;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    t_hb_sample  i_data      = '0;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    t_frame_beat o_data;

    delta_heartbeat_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );

    // Samples waiting to be sent and frame bytes waiting to come out
    t_hb_sample  pending_samples [$];
    t_frame_beat frame_bytes_due [$];
    t_hb_sample  last_queued = '0;

    int items_sent     = 0;
    int items_accepted = 0;
    int mismatches     = 0;
    int cycle_count    = 0;
    int tx_idle_pct    = 0;
    int rx_idle_pct    = 0;

    // Encoder state as the prediction sees it
    logic [7:0]  interval_reg  = INTERVAL_RESET;
    logic [7:0]  countdown     = INTERVAL_RESET;
    logic [5:0]  seq_num       = 6'd0;
    logic [7:0]  last_status   = 8'h00;
    logic [7:0]  last_battery  = 8'h00;
    logic [7:0]  last_signal   = 8'h00;
    logic [15:0] last_task     = 16'h0000;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Work out the frame for one accepted sample and advance the state
    task automatic predict_frame(input t_hb_sample s);
        logic [1:0]  ftype;
        logic        other_chg;
        logic [7:0]  body [$];
        t_frame_beat beat;
        countdown = countdown - 8'd1;
        other_chg = (s.status_code != last_status) || (s.signal_strength != last_signal)
                    || (s.current_task != last_task);
        if (countdown == 8'd0) begin
            ftype     = FT_FULL;
            countdown = interval_reg;
        end else if (!other_chg && s.battery_percent == last_battery) begin
            ftype = FT_NO_CHANGE;
        end else if (!other_chg) begin
            ftype = FT_BATTERY;
        end else begin
            ftype = FT_STATUS;
        end
        body.push_back({ftype, seq_num});
        seq_num = seq_num + 6'd1;
        body.push_back(s.device_short_id[7:0]);
        body.push_back(s.device_short_id[15:8]);
        case (ftype)
            FT_BATTERY: begin
                body.push_back(s.battery_percent);
            end
            FT_STATUS: begin
                body.push_back(s.status_code);
                body.push_back(s.battery_percent);
            end
            FT_FULL: begin
                body.push_back(s.status_code);
                body.push_back(s.battery_percent);
                body.push_back(s.signal_strength);
                body.push_back(s.current_task[7:0]);
                body.push_back(s.current_task[15:8]);
            end
            default: begin
            end
        endcase
        last_status  = s.status_code;
        last_battery = s.battery_percent;
        last_signal  = s.signal_strength;
        last_task    = s.current_task;
        for (int k = 0; k < body.size(); k++) begin
            beat.frame_byte = body[k];
            beat.frame_end  = (k == body.size() - 1);
            frame_bytes_due.push_back(beat);
        end
    endtask

    // Present samples at the falling edge; hold each until it is taken
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            i_stall <= ($urandom_range(99) < rx_idle_pct);
            if (!i_valid || items_accepted == items_sent) begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    i_data  <= pending_samples.pop_front();
                    i_valid <= 1'b1;
                    items_sent++;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Track register writes, accepted samples and outgoing frame bytes
    always @(posedge i_clk) begin : watch_channels
        t_frame_beat due;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else if (i_rst_n) begin
            if (i_cfg_we) begin
                interval_reg = i_cfg_wdata;
            end
            if (i_valid && !o_stall) begin
                predict_frame(i_data);
                items_accepted++;
            end
            if (o_valid && !i_stall) begin
                if (frame_bytes_due.size() == 0) begin
                    $display("%0t: unexpected frame byte, expected none, actual byte %02h end %0b",
                             $time, o_data.frame_byte, o_data.frame_end);
                    mismatches++;
                end else begin
                    due = frame_bytes_due.pop_front();
                    if (o_data.frame_byte !== due.frame_byte) begin
                        $display("%0t: frame_byte mismatch, expected %02h, actual %02h",
                                 $time, due.frame_byte, o_data.frame_byte);
                        mismatches++;
                    end
                    if (o_data.frame_end !== due.frame_end) begin
                        $display("%0t: frame_end mismatch, expected %0b, actual %0b",
                                 $time, due.frame_end, o_data.frame_end);
                        mismatches++;
                    end
                end
            end
        end
    end

    function automatic t_hb_sample sample(input logic [15:0] id, input logic [7:0] st,
                                          input logic [7:0] bat, input logic [7:0] sig,
                                          input logic [15:0] task_id);
        t_hb_sample s;
        s.device_short_id = id;
        s.status_code     = st;
        s.battery_percent = bat;
        s.signal_strength = sig;
        s.current_task    = task_id;
        return s;
    endfunction

    // Bias random fields toward their extremes now and then
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    task automatic queue_sample(input t_hb_sample s);
        pending_samples.push_back(s);
        last_queued = s;
    endtask

    // Mostly repeats and single-field changes so every frame type shows up often
    task automatic queue_random(input int count);
        t_hb_sample s;
        for (int k = 0; k < count; k++) begin
            s = last_queued;
            s.device_short_id = pick_word();
            case ($urandom_range(9))
                0, 1, 2: begin
                end
                3, 4:    s.battery_percent = pick_byte();
                5:       s.status_code     = pick_byte();
                6:       s.signal_strength = pick_byte();
                7:       s.current_task    = pick_word();
                default: begin
                    s.status_code     = pick_byte();
                    s.battery_percent = pick_byte();
                    s.signal_strength = pick_byte();
                    s.current_task    = pick_word();
                end
            endcase
            queue_sample(s);
        end
    endtask

    // Wait until every sample is taken and every frame byte has arrived
    task automatic wait_idle();
        while (pending_samples.size() != 0 || items_accepted != items_sent
               || frame_bytes_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_interval(input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle_pct = 26;
        rx_idle_pct = 45;

        // Directed: every frame type, id ignored in the compare, field extremes,
        // and a forced full frame on the 10th and 20th sample
        queue_sample(sample(16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000));
        queue_sample(sample(16'hFFFF, 8'h00, 8'h00, 8'h00, 16'h0000));
        queue_sample(sample(16'h0001, 8'h00, 8'hFF, 8'h00, 16'h0000));
        queue_sample(sample(16'h0002, 8'hFF, 8'hFF, 8'h00, 16'h0000));
        queue_sample(sample(16'h0003, 8'hFF, 8'hFF, 8'h80, 16'h0000));
        queue_sample(sample(16'h0004, 8'hFF, 8'hFF, 8'h80, 16'hFFFF));
        queue_sample(sample(16'h1234, 8'hFF, 8'hFF, 8'h80, 16'hFFFF));
        queue_sample(sample(16'h5678, 8'hFF, 8'hFF, 8'h7F, 16'hFFFF));
        queue_sample(sample(16'h9ABC, 8'hFF, 8'h00, 8'h7F, 16'hFFFF));
        queue_sample(sample(16'hDEF0, 8'hFF, 8'h00, 8'h7F, 16'hFFFF));
        queue_sample(sample(16'hA5A5, 8'h5A, 8'hA5, 8'h5A, 16'hA5A5));
        queue_sample(sample(16'h5A5A, 8'hA5, 8'h5A, 8'hA5, 16'h5A5A));
        queue_sample(sample(16'h5A5A, 8'hA5, 8'h5A, 8'hA5, 16'h5A5A));
        queue_sample(sample(16'hFFFF, 8'hFF, 8'hFF, 8'h7F, 16'hFFFF));
        queue_sample(sample(16'h0000, 8'hFF, 8'hFE, 8'h7F, 16'hFFFF));
        queue_sample(sample(16'h0000, 8'h00, 8'h00, 8'h80, 16'h0000));
        queue_sample(sample(16'h8000, 8'h00, 8'h01, 8'h80, 16'h0000));
        queue_sample(sample(16'h0001, 8'h00, 8'h01, 8'h80, 16'h8000));
        queue_sample(sample(16'h00FF, 8'h00, 8'h01, 8'h80, 16'h8000));
        queue_sample(sample(16'hFF00, 8'h12, 8'h34, 8'h56, 16'h789A));
        wait_idle();

        // Smallest interval: a full frame on every sample once reloaded
        write_interval(8'd1);
        queue_random(30);
        wait_idle();

        // Zero interval: the countdown wraps and the next full frame is 256 samples out
        tx_idle_pct = 45;
        rx_idle_pct = 26;
        write_interval(8'd0);
        queue_random(260);
        wait_idle();

        // Largest interval, then a mid value, with no idling on either side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_interval(8'd255);
        queue_random(40);
        wait_idle();
        write_interval(8'd7);
        queue_random(40);
        wait_idle();

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: delta_heartbeat_encoder.f
rtl/dhb_pkg.sv
rtl/dhb_framer.sv
rtl/dhb_serializer.sv
rtl/delta_heartbeat_encoder.sv
bench/delta_heartbeat_encoder_tb.sv
